[design/rlsc_pkg.sv]
// ----------------------------------------------------------------------------
// Radio link session controller package
// Item types, codes and constants shared by the session controller modules.
// ----------------------------------------------------------------------------
package rlsc_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 8;

  localparam logic [15:0] CONNECT_TIMEOUT_RST   = 16'd1000;
  localparam logic [15:0] LINK_LOST_TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] STATS_INTERVAL_RST    = 16'd1000;
  localparam logic [15:0] PING_INTERVAL_RST     = 16'd1000;
  localparam logic [7:0]  PING_REQUEST_RST      = 8'd1;
  localparam logic [7:0]  PING_RESPONSE_RST     = 8'd2;

  // Age in 100 ms units: saturation point and reciprocal of 100 as (5243 >> 19).
  localparam logic [31:0] AGE_SAT_MS   = 32'd25500;
  localparam logic [7:0]  AGE_SAT_VAL  = 8'd255;
  localparam logic [12:0] AGE_RECIP    = 13'd5243;
  localparam int          AGE_SHIFT    = 19;

  typedef enum logic [2:0] {
    REG_CONNECT_TIMEOUT   = 3'd0,
    REG_LINK_LOST_TIMEOUT = 3'd1,
    REG_STATS_INTERVAL    = 3'd2,
    REG_PING_INTERVAL     = 3'd3,
    REG_PING_REQUEST      = 3'd4,
    REG_PING_RESPONSE     = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_PACKET     = 3'd1,
    CMD_SCAN_START = 3'd2,
    CMD_SCAN_STOP  = 3'd3,
    CMD_CONNECT    = 3'd4,
    CMD_DISCONNECT = 3'd5,
    CMD_GET_STATS  = 3'd6
  } command_t;

  typedef enum logic [2:0] {
    PKT_BEACON     = 3'd0,
    PKT_CONNECT_OK = 3'd1,
    PKT_DISCONNECT = 3'd2,
    PKT_DATA       = 3'd3,
    PKT_STATS      = 3'd4
  } packet_type_t;

  typedef enum logic [3:0] {
    ACT_SCAN_RESULT   = 4'd0,
    ACT_SEND_CONNECT  = 4'd1,
    ACT_SEND_DISCONN  = 4'd2,
    ACT_CONNECTED     = 4'd3,
    ACT_DISCONNECTED  = 4'd4,
    ACT_STATS         = 4'd5,
    ACT_SEND_PING     = 4'd6,
    ACT_FORWARD_DATA  = 4'd7,
    ACT_RTT_MEASURED  = 4'd8,
    ACT_BAD_CONNECT   = 4'd9
  } action_t;

  localparam logic [15:0] REASON_HOST    = 16'd0;
  localparam logic [15:0] REASON_RADIO   = 16'd1;
  localparam logic [15:0] REASON_LINK    = 16'd2;
  localparam logic [15:0] REASON_TIMEOUT = 16'd3;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'b001,
    MODE_CONNECTING = 3'b010,
    MODE_SESSION    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [2:0]  packet_type;
    logic [7:0]  source_id;
    logic [7:0]  signal_strength;
    logic [7:0]  payload_length;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
  } evt_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  peer;
    logic [15:0] value_main;
    logic [7:0]  value_extra;
    logic        last_of_run;
  } res_item_t;

  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } res_pair_t;

  typedef struct packed {
    logic [15:0] connect_timeout;
    logic [15:0] link_lost_timeout;
    logic [15:0] stats_interval;
    logic [15:0] ping_interval;
    logic [7:0]  ping_request_code;
    logic [7:0]  ping_response_code;
  } cfg_t;

  function automatic res_item_t make_res(action_t act, logic [7:0] peer,
                                         logic [15:0] vmain, logic [7:0] vextra,
                                         logic last);
    res_item_t r;
    r.action      = act;
    r.peer        = peer;
    r.value_main  = vmain;
    r.value_extra = vextra;
    r.last_of_run = last;
    return r;
  endfunction

endpackage

[design/rlsc_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes up to two result items per cycle and hands
// out one per cycle while res_stall is low.
// ----------------------------------------------------------------------------
module rlsc_queue (
  input  logic               clk,
  input  logic               rst,
  input  rlsc_pkg::res_pair_t push,
  output logic               room,
  output logic               res_valid,
  input  logic               res_stall,
  output rlsc_pkg::res_item_t res
);
  import rlsc_pkg::*;

  res_item_t  mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != 3'd0);
  assign res       = mem[rd_ptr];
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

[design/rlsc_core.sv]
// ----------------------------------------------------------------------------
// Session controller core
// Link state, timers, ping bookkeeping and the discovered peer table; turns
// one registered event item into up to two result items.
// ----------------------------------------------------------------------------
module rlsc_core #(
  parameter int TABLE_ENTRIES = rlsc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rlsc_pkg::evt_item_t evt,
  input  rlsc_pkg::cfg_t      cfg,
  output rlsc_pkg::res_pair_t push
);
  import rlsc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  mode_t       mode, mode_next;
  logic [7:0]  peer_id, peer_id_next;
  logic [31:0] connect_time, connect_time_next;
  logic [31:0] peer_rx_time, peer_rx_time_next;
  logic [31:0] stats_time, stats_time_next;
  logic [31:0] ping_time, ping_time_next;
  logic [31:0] ping_sent_time, ping_sent_time_next;
  logic [7:0]  ping_token, ping_token_next;
  logic        ping_pending, ping_pending_next;
  logic        scan_reporting, scan_reporting_next;
  logic [15:0] measured_rtt, measured_rtt_next;

  logic        table_valid [TABLE_ENTRIES];
  logic [7:0]  table_id    [TABLE_ENTRIES];
  logic [31:0] table_seen  [TABLE_ENTRIES];

  logic [IW-1:0] slot;
  logic [7:0]    age100;
  logic          table_write;
  res_pair_t     pair;

  // Peer table lookup: matching entry, else first free entry, else entry 0.
  always_comb begin
    logic          hit;
    logic          free;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic [31:0]   age;
    logic [27:0]   prod;
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && table_valid[i] && table_id[i] == evt.source_id) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!free && !table_valid[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
    slot = hit ? hit_idx : (free ? free_idx : '0);
    age  = table_valid[slot] ? (evt.now_ms - table_seen[slot]) : 32'd0;
    prod = age[14:0] * AGE_RECIP;
    age100 = (age >= AGE_SAT_MS) ? AGE_SAT_VAL : prod[AGE_SHIFT +: 8];
  end

  always_comb begin
    logic [31:0] d_conn;
    logic [31:0] d_rx;
    logic [31:0] d_stats;
    logic [31:0] d_ping;
    logic        stats_due;
    logic        ping_due;
    logic [7:0]  token_inc;
    logic [15:0] rtt;
    d_conn    = evt.now_ms - connect_time;
    d_rx      = evt.now_ms - peer_rx_time;
    d_stats   = evt.now_ms - stats_time;
    d_ping    = evt.now_ms - ping_time;
    stats_due = (d_stats >= {16'd0, cfg.stats_interval});
    ping_due  = !ping_pending && (d_ping >= {16'd0, cfg.ping_interval});
    token_inc = ping_token + 8'd1;
    rtt       = 16'(evt.now_ms - ping_sent_time);

    mode_next           = mode;
    peer_id_next        = peer_id;
    connect_time_next   = connect_time;
    peer_rx_time_next   = peer_rx_time;
    stats_time_next     = stats_time;
    ping_time_next      = ping_time;
    ping_sent_time_next = ping_sent_time;
    ping_token_next     = ping_token;
    ping_pending_next   = ping_pending;
    scan_reporting_next = scan_reporting;
    measured_rtt_next   = measured_rtt;
    table_write         = 1'b0;
    pair.count          = 2'd0;
    pair.first          = '0;
    pair.second         = '0;

    case (evt.command)
      CMD_TICK: begin
        if (mode == MODE_CONNECTING && d_conn >= {16'd0, cfg.connect_timeout}) begin
          pair.count        = 2'd1;
          pair.first        = make_res(ACT_DISCONNECTED, peer_id, REASON_TIMEOUT, 8'd0, 1'b1);
          peer_id_next      = 8'd0;
          ping_pending_next = 1'b0;
          mode_next         = MODE_IDLE;
        end else if (mode == MODE_SESSION) begin
          if (d_rx >= {16'd0, cfg.link_lost_timeout}) begin
            pair.count        = 2'd1;
            pair.first        = make_res(ACT_DISCONNECTED, peer_id, REASON_LINK, 8'd0, 1'b1);
            peer_id_next      = 8'd0;
            ping_pending_next = 1'b0;
            mode_next         = MODE_IDLE;
          end else begin
            if (stats_due) begin
              stats_time_next = evt.now_ms;
            end
            if (ping_due) begin
              ping_token_next     = token_inc;
              ping_pending_next   = 1'b1;
              ping_sent_time_next = evt.now_ms;
              ping_time_next      = evt.now_ms;
            end
            if (stats_due && ping_due) begin
              pair.count  = 2'd2;
              pair.first  = make_res(ACT_STATS, peer_id, measured_rtt, 8'd0, 1'b0);
              pair.second = make_res(ACT_SEND_PING, peer_id, {8'd0, token_inc}, 8'd0, 1'b1);
            end else if (stats_due) begin
              pair.count = 2'd1;
              pair.first = make_res(ACT_STATS, peer_id, measured_rtt, 8'd0, 1'b1);
            end else if (ping_due) begin
              pair.count = 2'd1;
              pair.first = make_res(ACT_SEND_PING, peer_id, {8'd0, token_inc}, 8'd0, 1'b1);
            end
          end
        end
      end
      CMD_PACKET: begin
        if (evt.packet_type == PKT_BEACON) begin
          table_write = 1'b1;
          if (scan_reporting) begin
            pair.count = 2'd1;
            pair.first = make_res(ACT_SCAN_RESULT, evt.source_id,
                                  {8'd0, evt.signal_strength}, age100, 1'b1);
          end
        end else if (mode == MODE_CONNECTING && evt.packet_type == PKT_CONNECT_OK &&
                     evt.source_id == peer_id) begin
          peer_rx_time_next = evt.now_ms;
          stats_time_next   = evt.now_ms;
          ping_time_next    = evt.now_ms;
          ping_pending_next = 1'b0;
          mode_next         = MODE_SESSION;
          pair.count        = 2'd1;
          pair.first        = make_res(ACT_CONNECTED, peer_id, 16'd0, 8'd0, 1'b1);
        end else if (mode == MODE_SESSION && evt.source_id == peer_id) begin
          peer_rx_time_next = evt.now_ms;
          if (evt.packet_type == PKT_DISCONNECT) begin
            pair.count        = 2'd1;
            pair.first        = make_res(ACT_DISCONNECTED, peer_id, REASON_RADIO, 8'd0, 1'b1);
            peer_id_next      = 8'd0;
            ping_pending_next = 1'b0;
            mode_next         = MODE_IDLE;
          end else if (evt.packet_type == PKT_DATA && evt.payload_length != 8'd0) begin
            pair.count = 2'd1;
            pair.first = make_res(ACT_FORWARD_DATA, peer_id, 16'd0, evt.payload_length, 1'b1);
          end else if (evt.packet_type == PKT_STATS && evt.payload_length >= 8'd2 &&
                       evt.payload_first == cfg.ping_response_code && ping_pending &&
                       evt.payload_second == ping_token) begin
            measured_rtt_next = rtt;
            ping_pending_next = 1'b0;
            pair.count        = 2'd1;
            pair.first        = make_res(ACT_RTT_MEASURED, peer_id, rtt, 8'd0, 1'b1);
          end
        end
      end
      CMD_SCAN_START: begin
        scan_reporting_next = 1'b1;
      end
      CMD_SCAN_STOP: begin
        scan_reporting_next = 1'b0;
      end
      CMD_CONNECT: begin
        pair.count = 2'd1;
        if (evt.payload_length != 8'd1) begin
          pair.first = make_res(ACT_BAD_CONNECT, evt.payload_first, 16'd0, 8'd0, 1'b1);
        end else begin
          peer_id_next      = evt.payload_first;
          connect_time_next = evt.now_ms;
          mode_next         = MODE_CONNECTING;
          pair.first = make_res(ACT_SEND_CONNECT, evt.payload_first, 16'd0, 8'd0, 1'b1);
        end
      end
      CMD_DISCONNECT: begin
        if (mode == MODE_CONNECTING || mode == MODE_SESSION) begin
          pair.count        = 2'd2;
          pair.first        = make_res(ACT_SEND_DISCONN, peer_id, 16'd0, 8'd0, 1'b0);
          pair.second       = make_res(ACT_DISCONNECTED, peer_id, REASON_HOST, 8'd0, 1'b1);
          peer_id_next      = 8'd0;
          ping_pending_next = 1'b0;
          mode_next         = MODE_IDLE;
        end
      end
      CMD_GET_STATS: begin
        pair.count = 2'd1;
        pair.first = make_res(ACT_STATS, peer_id, measured_rtt, 8'd0, 1'b1);
      end
      default: begin
      end
    endcase

    push = pair;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      peer_id        <= 8'd0;
      connect_time   <= 32'd0;
      peer_rx_time   <= 32'd0;
      stats_time     <= 32'd0;
      ping_time      <= 32'd0;
      ping_sent_time <= 32'd0;
      ping_token     <= 8'd0;
      ping_pending   <= 1'b0;
      scan_reporting <= 1'b1;
      measured_rtt   <= 16'd0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        table_valid[i] <= 1'b0;
      end
    end else if (fire) begin
      mode           <= mode_next;
      peer_id        <= peer_id_next;
      connect_time   <= connect_time_next;
      peer_rx_time   <= peer_rx_time_next;
      stats_time     <= stats_time_next;
      ping_time      <= ping_time_next;
      ping_sent_time <= ping_sent_time_next;
      ping_token     <= ping_token_next;
      ping_pending   <= ping_pending_next;
      scan_reporting <= scan_reporting_next;
      measured_rtt   <= measured_rtt_next;
      if (table_write) begin
        table_valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && table_write) begin
      table_id[slot]   <= evt.source_id;
      table_seen[slot] <= evt.now_ms;
    end
  end

endmodule

[design/radio_link_session_controller_top.sv]
// ----------------------------------------------------------------------------
// Radio link session controller
// An accepted item is registered, then the core writes its results into the queue.
// Throughput: one item per cycle while evt_stall is low; the result port passes
// one result per cycle unless res_stall; two-result items thus raise evt_stall.
// Reset: synchronous; clears link state, ping state, the peer table valid bits
// and the result queue, and loads the register reset values.
// ----------------------------------------------------------------------------
module radio_link_session_controller_top #(
  parameter int TABLE_ENTRIES = rlsc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_stall,
  input  rlsc_pkg::evt_item_t evt,
  output logic                res_valid,
  input  logic                res_stall,
  output rlsc_pkg::res_item_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import rlsc_pkg::*;

  evt_item_t evt_reg;
  logic      evt_reg_valid;
  logic      room;
  logic      fire;
  cfg_t      cfg;
  res_pair_t push;

  assign fire      = evt_reg_valid && room;
  assign evt_stall = evt_reg_valid && !room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_reg_valid <= 1'b0;
    end else if (!evt_stall) begin
      evt_reg_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_reg <= evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_timeout    <= CONNECT_TIMEOUT_RST;
      cfg.link_lost_timeout  <= LINK_LOST_TIMEOUT_RST;
      cfg.stats_interval     <= STATS_INTERVAL_RST;
      cfg.ping_interval      <= PING_INTERVAL_RST;
      cfg.ping_request_code  <= PING_REQUEST_RST;
      cfg.ping_response_code <= PING_RESPONSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONNECT_TIMEOUT:   cfg.connect_timeout    <= cfg_data;
        REG_LINK_LOST_TIMEOUT: cfg.link_lost_timeout  <= cfg_data;
        REG_STATS_INTERVAL:    cfg.stats_interval     <= cfg_data;
        REG_PING_INTERVAL:     cfg.ping_interval      <= cfg_data;
        REG_PING_REQUEST:      cfg.ping_request_code  <= cfg_data[7:0];
        REG_PING_RESPONSE:     cfg.ping_response_code <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rlsc_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .evt  (evt_reg),
    .cfg  (cfg),
    .push (push)
  );

  rlsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
